// File: rtl/core/csdc_pkg.sv
// shared types and constants for the clock/stopwatch display controller
// no dependencies; imported by every module of the block but the checker
`default_nettype none

package csdc_pkg;

	// input op codes
	typedef enum logic [2:0] {
		OP_TICK      = 3'd0,
		OP_START     = 3'd1,
		OP_HOLD      = 3'd2,
		OP_CLOCK     = 3'd3,
		OP_BLANK     = 3'd4,
		OP_SET_COLOR = 3'd5
	} op_t;

	// display mode, one-hot
	typedef enum logic [3:0] {
		DISP_BLANK     = 4'b0001,
		DISP_CLOCK     = 4'b0010,
		DISP_STOPWATCH = 4'b0100,
		DISP_HOLD      = 4'b1000
	} mode_t;

	// what the redraw stage must do for one item
	typedef enum logic [2:0] {
		ACT_NONE       = 3'd0,
		ACT_TICK_BLANK = 3'd1,
		ACT_TICK_SHOW  = 3'd2,
		ACT_TICK_HOLD  = 3'd3,
		ACT_FORCE      = 3'd4,
		ACT_CLEAR      = 3'd5
	} act_t;

	// item control from the front stage
	typedef struct packed {
		act_t        act;
		logic [23:0] color;
	} cmd_t;

	// per-result flags after the redraw decision
	typedef struct packed {
		logic        draw;
		logic        colon_changed;
		logic        colon_lit;
		logic        clear;
		logic [23:0] color;
	} flags_t;

	localparam logic [23:0] RESET_COLOR = 24'hFF8000;

	// reciprocal constants for exact unsigned 32-bit division
	localparam logic [28:0] DIV1000_MAGIC = 29'h10624DD3;
	localparam int          DIV1000_SHIFT = 38;
	localparam logic [31:0] DIV60_MAGIC   = 32'h88888889;
	localparam int          DIV60_SHIFT   = 37;
	localparam logic [31:0] DIV3_MAGIC    = 32'hAAAAAAAB;
	localparam int          DIV3_SHIFT    = 33;

endpackage

`default_nettype wire

// File: rtl/core/csdc_front.sv
// front stage: op decode, mode and color state, stopwatch elapsed time
// depends on csdc_pkg
`default_nettype none

module csdc_front
	import csdc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        up_valid,
	output logic             up_ready,
	input  wire logic [2:0]  op,
	input  wire logic [31:0] now_ms,
	input  wire logic [16:0] day_seconds,
	input  wire logic [31:0] hold_seconds,
	input  wire logic [23:0] color,
	output logic             dn_valid,
	input  wire logic        dn_ready,
	output cmd_t             cmd_s1,
	output logic [31:0]      value_s1,
	output logic             is_sw_s1
);

	mode_t       mode_q, mode_d;
	logic [23:0] active_q, active_d;
	logic [23:0] clock_q, clock_d;
	logic [31:0] start_q, start_d;
	logic [31:0] held_q, held_d;
	logic        valid_s1;
	logic        take;
	act_t        act;
	logic [31:0] value;
	logic        is_sw;

	assign up_ready = !valid_s1 || dn_ready;
	assign take     = up_valid && up_ready;
	assign dn_valid = valid_s1;

	// decode one item against the current mode
	always_comb begin
		mode_d   = mode_q;
		active_d = active_q;
		clock_d  = clock_q;
		start_d  = start_q;
		held_d   = held_q;
		act      = ACT_NONE;
		value    = held_q;
		is_sw    = 1'b0;
		case (op)
			OP_TICK: begin
				case (mode_q)
					DISP_BLANK: act = ACT_TICK_BLANK;
					DISP_CLOCK: begin
						act   = ACT_TICK_SHOW;
						value = 32'(day_seconds);
					end
					DISP_STOPWATCH: begin
						act   = ACT_TICK_SHOW;
						value = now_ms - start_q;
						is_sw = 1'b1;
					end
					DISP_HOLD: act = ACT_TICK_HOLD;
					default: act = ACT_NONE;
				endcase
			end
			OP_START: begin
				mode_d   = DISP_STOPWATCH;
				start_d  = now_ms;
				active_d = color;
				act      = ACT_FORCE;
			end
			OP_HOLD: begin
				mode_d   = DISP_HOLD;
				held_d   = hold_seconds;
				active_d = color;
				act      = ACT_FORCE;
			end
			OP_CLOCK: begin
				mode_d   = DISP_CLOCK;
				active_d = clock_q;
				act      = ACT_FORCE;
			end
			OP_BLANK: begin
				mode_d = DISP_BLANK;
				act    = ACT_CLEAR;
			end
			OP_SET_COLOR: begin
				clock_d = color;
				if (mode_q == DISP_CLOCK) begin
					active_d = color;
					act      = ACT_FORCE;
				end
			end
			default: act = ACT_NONE;
		endcase
	end

	// mode and color state, updated on every input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= DISP_CLOCK;
			active_q <= RESET_COLOR;
			clock_q  <= RESET_COLOR;
			start_q  <= '0;
			held_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (take) begin
				mode_q   <= mode_d;
				active_q <= active_d;
				clock_q  <= clock_d;
				start_q  <= start_d;
				held_q   <= held_d;
			end
			if (up_ready) begin
				valid_s1 <= up_valid;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (up_ready) begin
			cmd_s1.act   <= act;
			cmd_s1.color <= active_d;
			value_s1     <= value;
			is_sw_s1     <= is_sw;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/csdc_div1000.sv
// milliseconds to seconds: exact divide by 1000 over two stages for stopwatch items, others pass through
// depends on csdc_pkg
`default_nettype none

module csdc_div1000
	import csdc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        up_valid,
	output logic             up_ready,
	input  wire cmd_t        cmd_in,
	input  wire logic [31:0] value_in,
	input  wire logic        is_sw_in,
	output logic             dn_valid,
	input  wire logic        dn_ready,
	output cmd_t             cmd_s3,
	output logic [31:0]      total_s3
);

	logic        vld_s2, vld_s3;
	logic        rdy_s2, rdy_s3;
	logic [60:0] prod_s2;
	logic [31:0] value_s2;
	logic        is_sw_s2;
	cmd_t        cmd_s2;

	assign rdy_s3   = !vld_s3 || dn_ready;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign up_ready = rdy_s2;
	assign dn_valid = vld_s3;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s2) begin
				vld_s2 <= up_valid;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	// reciprocal multiply, then shift out the quotient
	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			prod_s2  <= 61'(value_in) * 61'(DIV1000_MAGIC);
			value_s2 <= value_in;
			is_sw_s2 <= is_sw_in;
			cmd_s2   <= cmd_in;
		end
		if (rdy_s3) begin
			total_s3 <= is_sw_s2 ? 32'(prod_s2 >> DIV1000_SHIFT) : value_s2;
			cmd_s3   <= cmd_s2;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/csdc_redraw.sv
// redraw decision: shown value, forced redraw flag and colon state
// depends on csdc_pkg
`default_nettype none

module csdc_redraw
	import csdc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        up_valid,
	output logic             up_ready,
	input  wire cmd_t        cmd_in,
	input  wire logic [31:0] total_in,
	output logic             dn_valid,
	input  wire logic        dn_ready,
	output flags_t           flags_s4,
	output logic [31:0]      total_s4
);

	logic [31:0] shown_q, shown_d;
	logic        forced_q, forced_d;
	logic        colon_q, colon_d;
	logic        vld_s4;
	logic        take;
	logic        is_new;
	flags_t      flags;

	assign up_ready = !vld_s4 || dn_ready;
	assign take     = up_valid && up_ready;
	assign dn_valid = vld_s4;
	assign is_new   = forced_q || (total_in != shown_q);

	// per-item decision
	always_comb begin
		shown_d             = shown_q;
		forced_d            = forced_q;
		colon_d             = colon_q;
		flags.draw          = 1'b0;
		flags.colon_changed = 1'b0;
		flags.clear         = 1'b0;
		case (cmd_in.act)
			ACT_TICK_BLANK: begin
				colon_d             = 1'b0;
				flags.colon_changed = colon_q;
			end
			ACT_TICK_SHOW: begin
				if (is_new) begin
					shown_d             = total_in;
					forced_d            = 1'b0;
					flags.draw          = 1'b1;
					colon_d             = !colon_q;
					flags.colon_changed = 1'b1;
				end
			end
			ACT_TICK_HOLD: begin
				if (is_new) begin
					shown_d    = total_in;
					forced_d   = 1'b0;
					flags.draw = 1'b1;
				end
				colon_d             = 1'b1;
				flags.colon_changed = !colon_q;
			end
			ACT_FORCE: forced_d = 1'b1;
			ACT_CLEAR: flags.clear = 1'b1;
			default: forced_d = forced_q;
		endcase
		flags.colon_lit = colon_d;
		flags.color     = cmd_in.color;
	end

	// display state, updated once per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_q  <= '0;
			forced_q <= 1'b1;
			colon_q  <= 1'b0;
			vld_s4   <= 1'b0;
		end else begin
			if (take) begin
				shown_q  <= shown_d;
				forced_q <= forced_d;
				colon_q  <= colon_d;
			end
			if (up_ready) begin
				vld_s4 <= up_valid;
			end
		end
	end

	// stage 4 payload
	always_ff @(posedge clk) begin
		if (up_ready) begin
			flags_s4 <= flags;
			total_s4 <= total_in;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/csdc_digits.sv
// splits a seconds count into HH:MM:SS BCD digits, hours mod 24
// six stages ending in the output register; depends on csdc_pkg
`default_nettype none

module csdc_digits
	import csdc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        up_valid,
	output logic             up_ready,
	input  wire flags_t      flags_in,
	input  wire logic [31:0] total_in,
	output logic             dn_valid,
	input  wire logic        dn_ready,
	output flags_t           flags_s10,
	output logic [1:0]       hour_tens_s10,
	output logic [3:0]       hour_ones_s10,
	output logic [2:0]       minute_tens_s10,
	output logic [3:0]       minute_ones_s10,
	output logic [2:0]       second_tens_s10,
	output logic [3:0]       second_ones_s10
);

	// tens and ones of a value below 60
	function automatic logic [6:0] split_bcd(input logic [5:0] v);
		logic [2:0] tens;
		tens = '0;
		for (int i = 1; i < 6; i++) begin
			if (v >= 6'(i * 10)) begin
				tens = 3'(i);
			end
		end
		return {tens, 4'(v - 6'({tens, 3'b000}) - 6'({tens, 1'b0}))};
	endfunction

	logic        vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic        rdy_s5, rdy_s6, rdy_s7, rdy_s8, rdy_s9, rdy_s10;
	flags_t      flags_s5, flags_s6, flags_s7, flags_s8, flags_s9;
	logic [63:0] prod1_s5;
	logic [5:0]  tot_lo_s5;
	logic [26:0] q1_s6;
	logic [5:0]  sec_s6, sec_s7, sec_s8, sec_s9;
	logic [58:0] prod2_s7;
	logic [5:0]  q1_lo_s7;
	logic [20:0] q2_s8;
	logic [5:0]  min_s8, min_s9;
	logic [49:0] prod3_s9;
	logic [4:0]  q2_lo_s9;
	logic [26:0] q1;
	logic [20:0] q2;
	logic [16:0] q3;
	logic [4:0]  hour;
	logic [6:0]  hour_bcd, min_bcd, sec_bcd;

	assign rdy_s10  = !vld_s10 || dn_ready;
	assign rdy_s9   = !vld_s9 || rdy_s10;
	assign rdy_s8   = !vld_s8 || rdy_s9;
	assign rdy_s7   = !vld_s7 || rdy_s8;
	assign rdy_s6   = !vld_s6 || rdy_s7;
	assign rdy_s5   = !vld_s5 || rdy_s6;
	assign up_ready = rdy_s5;
	assign dn_valid = vld_s10;

	// quotients and remainders, each remainder kept to its low bits
	assign q1       = 27'(prod1_s5 >> DIV60_SHIFT);
	assign q2       = 21'(prod2_s7 >> DIV60_SHIFT);
	assign q3       = 17'(prod3_s9 >> DIV3_SHIFT);
	assign hour     = q2_lo_s9 - {q3[0], 4'b0000} - {q3[1:0], 3'b000};
	assign hour_bcd = split_bcd({1'b0, hour});
	assign min_bcd  = split_bcd(min_s9);
	assign sec_bcd  = split_bcd(sec_s9);

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else begin
			if (rdy_s5) begin
				vld_s5 <= up_valid;
			end
			if (rdy_s6) begin
				vld_s6 <= vld_s5;
			end
			if (rdy_s7) begin
				vld_s7 <= vld_s6;
			end
			if (rdy_s8) begin
				vld_s8 <= vld_s7;
			end
			if (rdy_s9) begin
				vld_s9 <= vld_s8;
			end
			if (rdy_s10) begin
				vld_s10 <= vld_s9;
			end
		end
	end

	// seconds split: /60, /60, /24 by reciprocal multiplies
	// low six bits of x - 60*q equal those of x + 4*q
	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			prod1_s5  <= 64'(total_in) * 64'(DIV60_MAGIC);
			tot_lo_s5 <= total_in[5:0];
			flags_s5  <= flags_in;
		end
		if (rdy_s6) begin
			q1_s6    <= q1;
			sec_s6   <= tot_lo_s5 + {q1[3:0], 2'b00};
			flags_s6 <= flags_s5;
		end
		if (rdy_s7) begin
			prod2_s7 <= 59'(q1_s6) * 59'(DIV60_MAGIC);
			q1_lo_s7 <= q1_s6[5:0];
			sec_s7   <= sec_s6;
			flags_s7 <= flags_s6;
		end
		if (rdy_s8) begin
			q2_s8    <= q2;
			min_s8   <= q1_lo_s7 + {q2[3:0], 2'b00};
			sec_s8   <= sec_s7;
			flags_s8 <= flags_s7;
		end
		if (rdy_s9) begin
			prod3_s9 <= 50'(q2_s8[20:3]) * 50'(DIV3_MAGIC);
			q2_lo_s9 <= q2_s8[4:0];
			min_s9   <= min_s8;
			sec_s9   <= sec_s8;
			flags_s9 <= flags_s8;
		end
	end

	// output register, digits zero unless drawn
	always_ff @(posedge clk) begin
		if (rdy_s10) begin
			flags_s10 <= flags_s9;
			if (flags_s9.draw) begin
				hour_tens_s10   <= hour_bcd[5:4];
				hour_ones_s10   <= hour_bcd[3:0];
				minute_tens_s10 <= min_bcd[6:4];
				minute_ones_s10 <= min_bcd[3:0];
				second_tens_s10 <= sec_bcd[6:4];
				second_ones_s10 <= sec_bcd[3:0];
			end else begin
				hour_tens_s10   <= '0;
				hour_ones_s10   <= '0;
				minute_tens_s10 <= '0;
				minute_ones_s10 <= '0;
				second_tens_s10 <= '0;
				second_ones_s10 <= '0;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/clock_stopwatch_display_controller.sv
// HH:MM:SS display controller for a six-digit display: blank, clock, stopwatch
// and hold modes. Every accepted tick or command gives exactly one result. The
// block takes one item per clock cycle while the output is not stalled. The
// pipeline holds the divide-by-1000 of the stopwatch time and the three
// reciprocal multiplies of the hours/minutes/seconds split, each followed by a
// register. Every stage stalls only when the stage after it is full, so bubbles
// close up under backpressure. After reset the block is in clock mode with the
// colon off, color 0xFF8000, and the first tick always redraws the digits.
// Depends on csdc_pkg, csdc_front, csdc_div1000, csdc_redraw, csdc_digits.
`default_nettype none

module clock_stopwatch_display_controller
	import csdc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// now_ms[31:0], day_seconds[48:32], hold_seconds[80:49], color[104:81]
	input  wire logic [111:0] s_tdata,
	// op[2:0]
	input  wire logic [2:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// hour_tens[1:0], hour_ones[5:2], minute_tens[8:6], minute_ones[12:9],
	// second_tens[15:13], second_ones[19:16], digit_color[43:20], colon_lit[44]
	output logic [47:0]       m_tdata,
	// draw_digits[0], colon_changed[1], clear_display[2]
	output logic [2:0]        m_tuser
);

	logic        f_valid, f_ready;
	cmd_t        f_cmd;
	logic [31:0] f_value;
	logic        f_is_sw;
	logic        d_valid, d_ready;
	cmd_t        d_cmd;
	logic [31:0] d_total;
	logic        r_valid, r_ready;
	flags_t      r_flags;
	logic [31:0] r_total;
	flags_t      o_flags;
	logic [1:0]  hour_tens;
	logic [3:0]  hour_ones;
	logic [2:0]  minute_tens;
	logic [3:0]  minute_ones;
	logic [2:0]  second_tens;
	logic [3:0]  second_ones;

	// decode and mode state
	csdc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.up_valid     (s_tvalid),
		.up_ready     (s_tready),
		.op           (s_tuser),
		.now_ms       (s_tdata[31:0]),
		.day_seconds  (s_tdata[48:32]),
		.hold_seconds (s_tdata[80:49]),
		.color        (s_tdata[104:81]),
		.dn_valid     (f_valid),
		.dn_ready     (f_ready),
		.cmd_s1       (f_cmd),
		.value_s1     (f_value),
		.is_sw_s1     (f_is_sw)
	);

	// stopwatch milliseconds to seconds
	csdc_div1000 u_div1000 (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (f_valid),
		.up_ready (f_ready),
		.cmd_in   (f_cmd),
		.value_in (f_value),
		.is_sw_in (f_is_sw),
		.dn_valid (d_valid),
		.dn_ready (d_ready),
		.cmd_s3   (d_cmd),
		.total_s3 (d_total)
	);

	// redraw and colon decision
	csdc_redraw u_redraw (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (d_valid),
		.up_ready (d_ready),
		.cmd_in   (d_cmd),
		.total_in (d_total),
		.dn_valid (r_valid),
		.dn_ready (r_ready),
		.flags_s4 (r_flags),
		.total_s4 (r_total)
	);

	// digit split and output register
	csdc_digits u_digits (
		.clk             (clk),
		.arst_n          (arst_n),
		.up_valid        (r_valid),
		.up_ready        (r_ready),
		.flags_in        (r_flags),
		.total_in        (r_total),
		.dn_valid        (m_tvalid),
		.dn_ready        (m_tready),
		.flags_s10       (o_flags),
		.hour_tens_s10   (hour_tens),
		.hour_ones_s10   (hour_ones),
		.minute_tens_s10 (minute_tens),
		.minute_ones_s10 (minute_ones),
		.second_tens_s10 (second_tens),
		.second_ones_s10 (second_ones)
	);

	// result packing
	assign m_tdata = {3'b000, o_flags.colon_lit, o_flags.color, second_ones, second_tens,
		minute_ones, minute_tens, hour_ones, hour_tens};
	assign m_tuser = {o_flags.clear, o_flags.colon_changed, o_flags.draw};

endmodule

`default_nettype wire

// File: rtl/core/csdc_checker.sv
// port-level checks for clock_stopwatch_display_controller, bound to the top
// depends on the top level's port list only
`default_nettype none

module csdc_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [47:0]  m_tdata,
	input wire logic [2:0]   m_tuser
);

	logic [4:0] inflight_q;
	logic       in_xfer, out_xfer;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	// items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			inflight_q <= inflight_q + 5'd1;
		end else if (out_xfer && !in_xfer) begin
			inflight_q <= inflight_q - 5'd1;
		end
	end

	// no result without an earlier input transfer
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> inflight_q != 5'd0)
		else $error("result shown with no item in flight");

	// stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// a blank command never draws digits
	a_clear_no_draw: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[2] && m_tuser[0]))
		else $error("clear and draw in one result");

	// undrawn digits are zero
	a_zero_digits: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[19:0] == 20'd0)
		else $error("digits set without draw");

	// drawn digits form a valid time of day
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata[1:0] < 2'd2 ||
		(m_tdata[1:0] == 2'd2 && m_tdata[5:2] < 4'd4)) && m_tdata[5:2] < 4'd10 &&
		m_tdata[8:6] < 3'd6 && m_tdata[12:9] < 4'd10 && m_tdata[15:13] < 3'd6 &&
		m_tdata[19:16] < 4'd10)
		else $error("drawn digits out of range");

endmodule

bind clock_stopwatch_display_controller csdc_checker u_checker (.*);

`default_nettype wire

// File: verif/display_result_checker.sv
`timescale 1ns / 100ps
// result checker for the clock/stopwatch display controller: watches both
// stream channels, predicts each display result and compares it field by field
// depends on csdc_pkg for the op and mode codes
module display_result_checker
	import csdc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	// now_ms[31:0], day_seconds[48:32], hold_seconds[80:49], color[104:81]
	input  wire logic [111:0] s_tdata,
	// op[2:0]
	input  wire logic [2:0]   s_tuser,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	// hour_tens[1:0], hour_ones[5:2], minute_tens[8:6], minute_ones[12:9],
	// second_tens[15:13], second_ones[19:16], digit_color[43:20], colon_lit[44]
	input  wire logic [47:0]  m_tdata,
	// draw_digits[0], colon_changed[1], clear_display[2]
	input  wire logic [2:0]   m_tuser,
	output int                mismatches,
	output int                outstanding
);

	// one display update as the block reports it
	typedef struct packed {
		logic        draw;
		logic [1:0]  hour_tens;
		logic [3:0]  hour_ones;
		logic [2:0]  minute_tens;
		logic [3:0]  minute_ones;
		logic [2:0]  second_tens;
		logic [3:0]  second_ones;
		logic [23:0] rgb;
		logic        colon_changed;
		logic        colon_lit;
		logic        clear;
	} face_t;

	// predicted display state
	mode_t       disp_mode  = DISP_CLOCK;
	logic [23:0] digit_rgb  = RESET_COLOR;
	logic [23:0] clock_rgb  = RESET_COLOR;
	logic [31:0] sw_start   = '0;
	logic [31:0] held_secs  = '0;
	logic [31:0] shown_secs = '0;
	logic        redraw_due = 1'b1;
	logic        colon_on   = 1'b0;

	face_t expected_displays[$];
	int    mismatch_total = 0;

	task automatic set_colon_lamp(inout face_t face, input logic lit);
		if (lit != colon_on) begin
			colon_on = lit;
			face.colon_changed = 1'b1;
		end
	endtask

	// redraw only on a new value or a forced redraw
	task automatic refresh_digits(inout face_t face, input logic [31:0] value,
			input logic toggle);
		logic [31:0] hrs;
		logic [31:0] mins;
		logic [31:0] secs;
		if (redraw_due || value != shown_secs) begin
			shown_secs = value;
			redraw_due = 1'b0;
			secs = value % 60;
			mins = (value / 60) % 60;
			hrs  = (value / 3600) % 24;
			face.draw        = 1'b1;
			face.hour_tens   = 2'(hrs / 10);
			face.hour_ones   = 4'(hrs % 10);
			face.minute_tens = 3'(mins / 10);
			face.minute_ones = 4'(mins % 10);
			face.second_tens = 3'(secs / 10);
			face.second_ones = 4'(secs % 10);
			if (toggle)
				set_colon_lamp(face, !colon_on);
		end
	endtask

	task automatic predict_display(input logic [2:0] op, input logic [31:0] now_ms,
			input logic [16:0] day, input logic [31:0] hold, input logic [23:0] rgb,
			output face_t face);
		logic [31:0] elapsed;
		face = '0;
		case (op)
		OP_TICK: begin
			case (disp_mode)
			DISP_BLANK: set_colon_lamp(face, 1'b0);
			DISP_CLOCK: refresh_digits(face, {15'd0, day}, 1'b1);
			DISP_STOPWATCH: begin
				elapsed = now_ms - sw_start;
				refresh_digits(face, elapsed / 32'd1000, 1'b1);
			end
			default: begin
				refresh_digits(face, held_secs, 1'b0);
				set_colon_lamp(face, 1'b1);
			end
			endcase
		end
		OP_START: begin
			disp_mode  = DISP_STOPWATCH;
			sw_start   = now_ms;
			digit_rgb  = rgb;
			redraw_due = 1'b1;
		end
		OP_HOLD: begin
			disp_mode  = DISP_HOLD;
			held_secs  = hold;
			digit_rgb  = rgb;
			redraw_due = 1'b1;
		end
		OP_CLOCK: begin
			disp_mode  = DISP_CLOCK;
			digit_rgb  = clock_rgb;
			redraw_due = 1'b1;
		end
		OP_BLANK: begin
			disp_mode  = DISP_BLANK;
			face.clear = 1'b1;
		end
		OP_SET_COLOR: begin
			clock_rgb = rgb;
			if (disp_mode == DISP_CLOCK) begin
				digit_rgb  = rgb;
				redraw_due = 1'b1;
			end
		end
		default: ;
		endcase
		face.rgb       = digit_rgb;
		face.colon_lit = colon_on;
	endtask

	task automatic compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", field, want, got);
			mismatch_total++;
		end
	endtask

	// result side first, then the new item
	always @(posedge clk or negedge arst_n) begin
		face_t want;
		face_t got;
		if (!arst_n) begin
			disp_mode  = DISP_CLOCK;
			digit_rgb  = RESET_COLOR;
			clock_rgb  = RESET_COLOR;
			sw_start   = '0;
			held_secs  = '0;
			shown_secs = '0;
			redraw_due = 1'b1;
			colon_on   = 1'b0;
			expected_displays.delete();
			outstanding <= 0;
			mismatches  <= mismatch_total;
		end else begin
			if (m_tvalid && m_tready) begin
				got.draw          = m_tuser[0];
				got.colon_changed = m_tuser[1];
				got.clear         = m_tuser[2];
				got.hour_tens     = m_tdata[1:0];
				got.hour_ones     = m_tdata[5:2];
				got.minute_tens   = m_tdata[8:6];
				got.minute_ones   = m_tdata[12:9];
				got.second_tens   = m_tdata[15:13];
				got.second_ones   = m_tdata[19:16];
				got.rgb           = m_tdata[43:20];
				got.colon_lit     = m_tdata[44];
				if (expected_displays.size() == 0) begin
					$error("result with no item waiting: tdata %h tuser %b", m_tdata, m_tuser);
					mismatch_total++;
				end else begin
					want = expected_displays.pop_front();
					compare_field("draw_digits", 32'(want.draw), 32'(got.draw));
					compare_field("hour_tens", 32'(want.hour_tens), 32'(got.hour_tens));
					compare_field("hour_ones", 32'(want.hour_ones), 32'(got.hour_ones));
					compare_field("minute_tens", 32'(want.minute_tens),
						32'(got.minute_tens));
					compare_field("minute_ones", 32'(want.minute_ones),
						32'(got.minute_ones));
					compare_field("second_tens", 32'(want.second_tens),
						32'(got.second_tens));
					compare_field("second_ones", 32'(want.second_ones),
						32'(got.second_ones));
					compare_field("digit_color", 32'(want.rgb), 32'(got.rgb));
					compare_field("colon_changed", 32'(want.colon_changed),
						32'(got.colon_changed));
					compare_field("colon_lit", 32'(want.colon_lit), 32'(got.colon_lit));
					compare_field("clear_display", 32'(want.clear), 32'(got.clear));
				end
			end
			if (s_tvalid && s_tready) begin
				predict_display(s_tuser, s_tdata[31:0], s_tdata[48:32], s_tdata[80:49],
					s_tdata[104:81], want);
				expected_displays.push_back(want);
			end
			outstanding <= expected_displays.size();
			mismatches  <= mismatch_total;
		end
	end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// stimulus and verdict for the clock/stopwatch display controller
// depends on csdc_pkg, the block itself and display_result_checker
module testbench;
	import csdc_pkg::*;

	// op codes the block leaves unused
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	localparam int RANDOM_ITEMS  = 1250;
	localparam int LONG_HOLD_OFF = 400;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 20;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [111:0] s_tdata  = '0;
	logic [2:0]   s_tuser  = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [47:0]  m_tdata;
	logic [2:0]   m_tuser;
	int           mismatches;
	int           outstanding;

	int items_sent     = 0;
	int hold_off_asked = 0;
	bit sender_burst   = 1'b0;

	clock_stopwatch_display_controller DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	display_result_checker result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// offer one item after a random gap and wait for its transfer
	task automatic send_item(input logic [2:0] op, input logic [31:0] now_ms,
			input logic [16:0] day, input logic [31:0] hold, input logic [23:0] rgb);
		int gap;
		gap = sender_burst ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'd0, rgb, hold, day, now_ms};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (op <= OP_SET_COLOR)
			items_sent++;
	endtask

	// stop offering until every result is back
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// mostly in range, sometimes up to the full field width
	function automatic logic [16:0] rand_day();
		return 17'(($urandom_range(0, 7) == 0) ? $urandom_range(86400, 131071)
			: $urandom_range(0, 86399));
	endfunction

	// well-formed command/tick runs with random content, plus some noise
	task automatic random_sequence();
		int          kind;
		int          len;
		logic [31:0] ms;
		logic [31:0] hold;
		logic [16:0] day;
		kind = $urandom_range(0, 9);
		len  = $urandom_range(2, 12);
		sender_burst = ($urandom_range(0, 5) == 0);
		case (kind)
		0, 1: begin
			// stopwatch run, time moving forward
			ms = $urandom;
			send_item(OP_START, ms, rand_day(), $urandom, 24'($urandom));
			repeat (len) begin
				ms = ms + $urandom_range(0, 1500);
				send_item(OP_TICK, ms, rand_day(), $urandom, 24'($urandom));
			end
		end
		2, 3: begin
			// clock run, seconds advancing slowly
			send_item(OP_CLOCK, $urandom, rand_day(), $urandom, 24'($urandom));
			day = rand_day();
			repeat (len) begin
				day = 17'(day + $urandom_range(0, 2));
				send_item(OP_TICK, $urandom, day, $urandom, 24'($urandom));
			end
		end
		4, 5: begin
			// hold, mostly small durations
			hold = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200000);
			send_item(OP_HOLD, $urandom, rand_day(), hold, 24'($urandom));
			repeat ($urandom_range(1, 4))
				send_item(OP_TICK, $urandom, rand_day(), $urandom, 24'($urandom));
		end
		6: begin
			send_item(OP_BLANK, $urandom, rand_day(), $urandom, 24'($urandom));
			repeat ($urandom_range(1, 3))
				send_item(OP_TICK, $urandom, rand_day(), $urandom, 24'($urandom));
		end
		7: begin
			// color change followed by ticks
			send_item(OP_SET_COLOR, $urandom, rand_day(), $urandom, 24'($urandom));
			repeat ($urandom_range(1, 4))
				send_item(OP_TICK, $urandom, rand_day(), $urandom, 24'($urandom));
		end
		default: begin
			repeat (len)
				send_item(3'($urandom_range(0, 7)), $urandom,
					17'($urandom_range(0, 131071)), $urandom, 24'($urandom));
		end
		endcase
	endtask

	// result side: random stalls, bursts without stalls, one long hold-off
	initial begin
		int stall;
		int taken;
		int hold_off_done;
		taken = 0;
		hold_off_done = 0;
		forever begin
			if (hold_off_asked != hold_off_done) begin
				hold_off_done = hold_off_asked;
				stall = LONG_HOLD_OFF;
			end else if ((taken / 40) % 5 == 2) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, 5);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			taken++;
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$error("no transfer for %0d cycles", IDLE_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int  base;
		bit  hold_off_done;
		bit  drain_done;
		hold_off_done = 1'b0;
		drain_done = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// clock mode after reset: first tick draws, the same second does not
		send_item(OP_TICK, 32'd0, 17'd0, 32'd0, 24'd0);
		send_item(OP_TICK, 32'd0, 17'd0, 32'd0, 24'd0);
		send_item(OP_TICK, '1, 17'd86399, '1, '1);
		// time of day beyond a day, hours wrap
		send_item(OP_TICK, 32'd0, 17'h1FFFF, 32'd0, 24'd0);
		// color change in clock mode forces a redraw of the same value
		send_item(OP_SET_COLOR, 32'd0, 17'd0, 32'd0, 24'h000000);
		send_item(OP_TICK, 32'd0, 17'h1FFFF, 32'd0, 24'd0);
		// stopwatch across the millisecond counter wrap
		send_item(OP_START, 32'hFFFF_FF00, 17'd0, 32'd0, 24'hFFFFFF);
		send_item(OP_TICK, 32'h0000_00FF, 17'd0, 32'd0, 24'd0);
		send_item(OP_TICK, 32'hFFFF_FEFF, 17'd0, 32'd0, 24'd0);
		// hold of the largest value, drawn once
		send_item(OP_HOLD, 32'd0, 17'd0, 32'hFFFF_FFFF, 24'h123456);
		send_item(OP_TICK, 32'd0, 17'd0, 32'd0, 24'd0);
		send_item(OP_TICK, 32'd0, 17'd0, 32'd0, 24'd0);
		send_item(OP_HOLD, 32'd0, 17'd0, 32'd0, 24'hA5A5A5);
		send_item(OP_TICK, 32'd0, 17'd0, 32'd0, 24'd0);
		// blank: clear now, colon off on the next tick
		send_item(OP_BLANK, 32'd0, 17'd0, 32'd0, 24'd0);
		send_item(OP_TICK, 32'd0, 17'd0, 32'd0, 24'd0);
		send_item(OP_TICK, 32'd0, 17'd0, 32'd0, 24'd0);
		send_item(OP_SPARE_6, '1, '1, '1, '1);
		send_item(OP_SPARE_7, '1, '1, '1, '1);
		// color set while blank only takes effect on return to clock
		send_item(OP_SET_COLOR, 32'd0, 17'd0, 32'd0, 24'hFFFFFF);
		send_item(OP_CLOCK, 32'd0, 17'd0, 32'd0, 24'd0);
		send_item(OP_TICK, 32'd0, 17'd43261, 32'd0, 24'd0);
		// stopwatch second boundary
		send_item(OP_START, 32'd0, 17'd0, 32'd0, 24'd0);
		send_item(OP_TICK, 32'd999, 17'd0, 32'd0, 24'd0);
		send_item(OP_TICK, 32'd1000, 17'd0, 32'd0, 24'd0);
		wait_for_drain();

		base = items_sent;
		while (items_sent - base < RANDOM_ITEMS) begin
			if (!hold_off_done && items_sent - base >= 400) begin
				hold_off_done = 1'b1;
				hold_off_asked++;
			end
			if (!drain_done && items_sent - base >= 800) begin
				drain_done = 1'b1;
				wait_for_drain();
			end
			random_sequence();
		end

		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/csdc_pkg.sv
rtl/core/csdc_front.sv
rtl/core/csdc_div1000.sv
rtl/core/csdc_redraw.sv
rtl/core/csdc_digits.sv
rtl/core/clock_stopwatch_display_controller.sv
rtl/core/csdc_checker.sv
verif/display_result_checker.sv
verif/testbench.sv
